/* hdl/lrs_pkg.sv */
// Shared types, constants and the sigmoid lookup table for the logistic regression scorer.
package lrs_pkg;

  localparam int IDX_W     = 9;   // weight_index and feature_count width
  localparam int EPS_W     = 15;  // clamp_eps width
  localparam int PROB_W    = 16;  // Q0.16 probability
  localparam int ACC_W     = 40;  // running sum, Q.24
  localparam int SUM_FRAC  = 24;
  localparam int SUM_W     = 28;  // saturated final sum, Q4.24
  localparam int PROD_W    = 32;  // rescaled product always fits here
  localparam int BIAS_W    = 28;  // rescaled bias always fits here
  localparam int TBL_IDX_W = 8;
  localparam int TBL_DEPTH = 256;
  localparam int CFG_IDX_W = 1;

  localparam logic [IDX_W-1:0] POS_MAX = '1;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_FEATURE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEATURE_COUNT = 1'b0,
    REG_CLAMP_EPS     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic acc_en;    // product goes into the sum
    logic res;       // last feature: a result follows
    logic mismatch;  // feature count error
  } lrs_ctl_t;

  typedef logic [TBL_DEPTH-1:0][PROB_W-1:0] sig_tbl_t;

  // Q62 multiply, keeps bits 125:62 of the full product
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // unsigned shift-subtract quotient, used only while building the table
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid of bucket midpoints -8 + (2k+1)/32, evaluated at elaboration
  function automatic sig_tbl_t build_sig_table();
    logic [63:0] one;
    logic [63:0] term;
    logic [63:0] base;
    logic [63:0] pw;
    logic [63:0] d;
    logic [TBL_DEPTH-1:0][PROB_W-1:0] pos;
    sig_tbl_t tbl;
    one  = 64'd1 << 62;
    term = one;
    base = one;
    pos  = '0;
    tbl  = '0;
    // exp(-1/32) by Taylor series
    for (int n = 1; n <= 12; n++) begin
      term = div_u64(term, 64'd32 * 64'(n));
      if ((n & 1) != 0) begin
        base = base - term;
      end else begin
        base = base + term;
      end
    end
    pw = one;
    for (int j = 1; j <= 255; j++) begin
      pw = mul_q62(pw, base);
      if ((j & 1) != 0) begin
        d      = (one + pw) >> 16;
        pos[j] = PROB_W'(div_u64(one + (d >> 1), d));
      end
    end
    for (int k = 0; k < TBL_DEPTH; k++) begin
      if (k >= 128) begin
        tbl[k] = pos[2 * k - 255];
      end else begin
        tbl[k] = PROB_W'(17'd65536 - 17'(pos[255 - 2 * k]));
      end
    end
    return tbl;
  endfunction

  localparam sig_tbl_t SIG_TABLE = build_sig_table();

endpackage

/* hdl/lrs_weight_mem.sv */
// Weight and bias store: one write port, two registered read ports, clearing pass after reset.
module lrs_weight_mem import lrs_pkg::*; #(
  parameter int DEPTH  = 257,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [DATA_W-1:0]        rd_data_a,
  output logic [DATA_W-1:0]        rd_data_b,
  output logic                     clearing
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* hdl/lrs_mac.sv */
// Multiply stage and saturating accumulator of the scorer.
module lrs_mac import lrs_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          s1_valid,
  input  lrs_ctl_t                      s1_ctl,
  input  logic signed [VALUE_BITS-1:0]  s1_value,
  input  logic signed [VALUE_BITS-1:0]  weight,
  input  logic signed [VALUE_BITS-1:0]  bias_raw,
  output logic                          s3_valid,
  output logic                          s3_mismatch,
  output logic signed [ACC_W-1:0]       s3_pre,
  output logic signed [BIAS_W-1:0]      s3_bias
);

  localparam int FRAC = VALUE_BITS - 4;
  localparam int PSH  = SUM_FRAC - 2 * FRAC;
  localparam int PLSH = (PSH > 0) ? PSH : 0;
  localparam int PRSH = (PSH < 0) ? -PSH : 0;
  localparam int BSH  = SUM_FRAC - FRAC;
  localparam int BLSH = (BSH > 0) ? BSH : 0;
  localparam int BRSH = (BSH < 0) ? -BSH : 0;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    if (v[ACC_W] != v[ACC_W-1]) begin
      return v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return v[ACC_W-1:0];
  endfunction

  logic signed [2*VALUE_BITS-1:0] prod_full;
  logic signed [63:0]             prod_ext;
  logic signed [63:0]             prod_scaled;
  logic signed [63:0]             bias_ext;
  logic signed [63:0]             bias_scaled;

  logic                     s2_valid;
  lrs_ctl_t                 s2_ctl;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [BIAS_W-1:0] s2_bias;

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  pre;

  // stage 1: product and bias brought to 24 fraction bits (floor on right shift)
  always_comb begin
    prod_full   = s1_value * weight;
    prod_ext    = {{(64-2*VALUE_BITS){prod_full[2*VALUE_BITS-1]}}, prod_full};
    prod_scaled = (prod_ext <<< PLSH) >>> PRSH;
    bias_ext    = {{(64-VALUE_BITS){bias_raw[VALUE_BITS-1]}}, bias_raw};
    bias_scaled = (bias_ext <<< BLSH) >>> BRSH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_ctl  <= s1_ctl;
      s2_prod <= prod_scaled[PROD_W-1:0];
      s2_bias <= bias_scaled[BIAS_W-1:0];
    end
  end

  // stage 2: accumulate
  always_comb begin
    sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){s2_prod[PROD_W-1]}}, s2_prod};
    pre = s2_ctl.acc_en ? sat_acc(sum) : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid && s2_ctl.res;
      if (s2_valid) begin
        acc <= s2_ctl.res ? '0 : pre;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid && s2_ctl.res) begin
      s3_mismatch <= s2_ctl.mismatch;
      s3_pre      <= pre;
      s3_bias     <= s2_bias;
    end
  end

endmodule

/* hdl/lrs_sigmoid.sv */
// Bias add, range saturation, sigmoid table lookup and probability clamp.
module lrs_sigmoid import lrs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     s3_valid,
  input  logic                     s3_mismatch,
  input  logic signed [ACC_W-1:0]  s3_pre,
  input  logic signed [BIAS_W-1:0] s3_bias,
  input  logic [EPS_W-1:0]         clamp_eps,
  output logic                     res_valid,
  output logic [PROB_W-1:0]        res_prob,
  output logic                     res_status
);

  logic signed [ACC_W:0]  tot;
  logic                   hi_ovf;
  logic                   lo_ovf;
  logic [TBL_IDX_W-1:0]   idx;

  logic                   s4_valid;
  logic                   s4_mismatch;
  logic [TBL_IDX_W-1:0]   s4_idx;

  logic [PROB_W:0]        entry;
  logic [PROB_W:0]        lo;
  logic [PROB_W:0]        hi;
  logic [PROB_W:0]        p;

  // stage 3: sum + bias, saturate to Q4.24, index = (sum + 8.0) >> 20
  always_comb begin
    tot    = {s3_pre[ACC_W-1], s3_pre} + {{(ACC_W+1-BIAS_W){s3_bias[BIAS_W-1]}}, s3_bias};
    hi_ovf = !tot[ACC_W] && (|tot[ACC_W-1:SUM_W-1]);
    lo_ovf = tot[ACC_W] && !(&tot[ACC_W-1:SUM_W-1]);
    if (hi_ovf) begin
      idx = '1;
    end else if (lo_ovf) begin
      idx = '0;
    end else begin
      idx = {~tot[SUM_W-1], tot[SUM_W-2:SUM_W-TBL_IDX_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s3_valid) begin
      s4_mismatch <= s3_mismatch;
      s4_idx      <= idx;
    end
  end

  // stage 4: table lookup and clamp into [eps, 1 - eps]
  always_comb begin
    entry = {1'b0, SIG_TABLE[s4_idx]};
    lo    = (PROB_W+1)'(clamp_eps);
    hi    = (PROB_W+1)'(17'd65536) - (PROB_W+1)'(clamp_eps);
    p     = (entry < lo) ? lo : entry;
    if (p > hi) begin
      p = hi;
    end
    if (p[PROB_W]) begin
      p = {1'b0, {PROB_W{1'b1}}};
    end
    res_valid  = s4_valid;
    res_prob   = s4_mismatch ? '0 : p[PROB_W-1:0];
    res_status = s4_mismatch;
  end

endmodule

/* hdl/logistic_regression_score.sv */
// Logistic regression scorer: weight store, MAC, sigmoid lookup and output register.
// Throughput: one request per cycle, loads and features alike, while in_stall is low.
// Path of a result from its last feature taken to the output: weight read, multiply,
// accumulate, bias add, table lookup, output register.
// Reset: weights clear by a pass over all MAX_FEATURES+1 entries (257 by default) of the
// weight memory, with in_stall high; sum, position and registers reset at once.
module logistic_regression_score import lrs_pkg::*; #(
  parameter int MAX_FEATURES = 256,
  parameter int VALUE_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [EPS_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation,
  input  logic [IDX_W-1:0]             weight_index,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [PROB_W-1:0]            probability,
  output logic                         status
);

  localparam int DEPTH  = MAX_FEATURES + 1;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [IDX_W-1:0] feature_count;
  logic [EPS_W-1:0] clamp_eps;
  logic [IDX_W-1:0] pos;

  logic             in_accept;
  logic             is_feat;
  logic             pos_ok;
  logic [IDX_W-1:0] pos_inc;
  logic             mismatch;
  logic             advance;
  logic             clearing;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [VALUE_BITS-1:0] weight;
  logic [VALUE_BITS-1:0] bias_raw;

  logic                         s1_valid;
  lrs_ctl_t                     s1_ctl;
  logic signed [VALUE_BITS-1:0] s1_value;

  logic                     s3_valid;
  logic                     s3_mismatch;
  logic signed [ACC_W-1:0]  s3_pre;
  logic signed [BIAS_W-1:0] s3_bias;

  logic              res_valid;
  logic [PROB_W-1:0] res_prob;
  logic              res_status;

  // pipeline holds only when a result would overrun a waiting one
  assign advance   = !(out_valid && out_stall && res_valid);
  assign in_stall  = clearing || !advance;
  assign in_accept = in_valid && !in_stall;
  assign is_feat   = (operation == OP_FEATURE);

  always_comb begin
    pos_ok   = (pos < feature_count) && (int'(pos) < MAX_FEATURES);
    pos_inc  = (pos != POS_MAX) ? pos + IDX_W'(1) : pos;
    mismatch = (feature_count == '0) || (int'(feature_count) > MAX_FEATURES) ||
               (pos_inc != feature_count);
    wr_en     = in_accept && !is_feat && (int'(weight_index) <= MAX_FEATURES);
    wr_addr   = ADDR_W'(weight_index);
    rd_en     = in_accept && is_feat;
    rd_addr_a = pos_ok ? ADDR_W'(pos) : '0;
    rd_addr_b = (int'(feature_count) <= MAX_FEATURES) ? ADDR_W'(feature_count) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_count <= IDX_W'(1);
      clamp_eps     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FEATURE_COUNT: feature_count <= cfg_data[IDX_W-1:0];
        REG_CLAMP_EPS:     clamp_eps     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_accept && is_feat) begin
        pos <= last ? '0 : pos_inc;
      end
      if (advance) begin
        s1_valid <= in_accept && is_feat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && is_feat) begin
      s1_value        <= value;
      s1_ctl.acc_en   <= pos_ok;
      s1_ctl.res      <= last;
      s1_ctl.mismatch <= mismatch;
    end
  end

  lrs_weight_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (VALUE_BITS)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (value),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (weight),
    .rd_data_b (bias_raw),
    .clearing  (clearing)
  );

  lrs_mac #(
    .VALUE_BITS (VALUE_BITS)
  ) u_mac (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .s1_valid    (s1_valid),
    .s1_ctl      (s1_ctl),
    .s1_value    (s1_value),
    .weight      (weight),
    .bias_raw    (bias_raw),
    .s3_valid    (s3_valid),
    .s3_mismatch (s3_mismatch),
    .s3_pre      (s3_pre),
    .s3_bias     (s3_bias)
  );

  lrs_sigmoid u_sig (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .s3_valid    (s3_valid),
    .s3_mismatch (s3_mismatch),
    .s3_pre      (s3_pre),
    .s3_bias     (s3_bias),
    .clamp_eps   (clamp_eps),
    .res_valid   (res_valid),
    .res_prob    (res_prob),
    .res_status  (res_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && advance) begin
      probability <= res_prob;
      status      <= res_status;
    end
  end

  // no request gets in while the weight memory is being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("request accepted during weight clearing");

  // an error result never carries a probability
  a_err_prob_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (probability == '0))
    else $error("mismatch result with nonzero probability");

  // the last feature of a vector restarts the position count
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_feat && last) |=> (pos == '0))
    else $error("feature position not cleared after last feature");

  // a waiting result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(probability) && $stable(status)))
    else $error("stalled result changed");

endmodule
